// ===== rtl/core/lcss_pkg.sv =====
// Shared types and constants for the lock combination sweep sequencer.
// No dependencies; imported by the controller, datapath, top level and checker.
`default_nettype none

package lcss_pkg;

    // Widths of digits, attempt counter and dwell counter
    localparam int POS_W   = 8;
    localparam int ATT_W   = 16;
    localparam int DWELL_W = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIRST_ZONE  = 3'd0;
    localparam logic [2:0] CFG_ZONE_STEP   = 3'd1;
    localparam logic [2:0] CFG_POS_COUNT   = 3'd2;
    localparam logic [2:0] CFG_ZONE_COUNT  = 3'd3;
    localparam logic [2:0] CFG_UP_WAIT     = 3'd4;
    localparam logic [2:0] CFG_DOWN_WAIT   = 3'd5;

    // Input action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_MOTION  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_IGNORE  = 2'd3;

    // Completion status codes
    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_ALL    = 2'd1;
    localparam logic [1:0] ST_OPENED = 2'd2;

    // Sequencer phase; the value doubles as the motion command
    typedef enum logic [2:0] {
        PH_SELECT = 3'd0,
        PH_CW2    = 3'd1,
        PH_FIRST  = 3'd2,
        PH_CCW1   = 3'd3,
        PH_SECOND = 3'd4,
        PH_THIRD  = 3'd5,
        PH_UP     = 3'd6,
        PH_DOWN   = 3'd7
    } t_phase;

    // Controller to datapath commands
    typedef struct packed {
        logic       scan;       // step to the next candidate combination
        logic       load_last;  // park digits on the last valid combination
        logic       att_inc;    // count one attempt
        logic       dwell_clr;  // restart the dwell counter
        logic       dwell_inc;  // one tick of dwell
        logic       capture;    // load the output register
        t_phase     out_motion;
        logic [1:0] out_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic valid;      // candidate has distinct neighbouring digits
        logic exhausted;  // first digit rolled past the dial
        logic cw2;        // candidate needs a clockwise-twice reset
        logic up_done;    // up dwell reached after this tick
        logic down_done;  // down dwell reached after this tick
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/lcss_ctrl.sv =====
// Sequencer controller: handshake sequencing, phase, entry flag and done code.
// Depends on lcss_pkg; drives lcss_dp through t_dp_cmd and reads t_dp_sts.
`default_nettype none

module lcss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_action,
    input  wire logic              i_switch_active,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lcss_pkg::t_dp_cmd      o_cmd,
    input  wire lcss_pkg::t_dp_sts i_sts
);
    import lcss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESULT
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    t_phase      r_phase, n_phase;
    logic        r_entered, n_entered;
    logic [1:0]  r_done, n_done;
    logic [1:0]  r_action, n_action;
    logic        r_sw, n_sw;
    logic        r_out_valid, n_out_valid;
    logic        motion;
    logic        tick;

    assign motion      = (r_action == ACT_MOTION);
    assign tick        = (r_action == ACT_TICK);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_entered   = r_entered;
        n_done      = r_done;
        n_action    = r_action;
        n_sw        = r_sw;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.out_motion = (r_done != ST_RUN) ? PH_SELECT : r_phase;
        o_cmd.out_status = r_done;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_action;
                    n_sw     = i_switch_active;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                if (r_action == ACT_RESTART) begin
                    n_phase         = PH_SELECT;
                    n_entered       = 1'b0;
                    n_done          = ST_RUN;
                    o_cmd.dwell_clr = 1'b1;
                end else if (r_action != ACT_IGNORE && r_done == ST_RUN) begin
                    case (r_phase)
                        PH_SELECT: begin
                            n_state = S_SCAN;
                        end
                        PH_CW2, PH_FIRST, PH_CCW1, PH_SECOND, PH_THIRD: begin
                            if (motion) begin
                                n_phase = t_phase'(r_phase + 3'd1);
                            end
                            n_entered = !motion;
                        end
                        PH_UP: begin
                            if (!r_entered) begin
                                o_cmd.att_inc   = 1'b1;
                                o_cmd.dwell_clr = 1'b1;
                                n_entered       = 1'b1;
                            end else begin
                                o_cmd.dwell_inc = tick;
                                if (i_sts.up_done) begin
                                    n_phase   = PH_DOWN;
                                    n_entered = 1'b0;
                                end else begin
                                    n_entered = 1'b1;
                                end
                            end
                            if (r_sw) begin
                                n_done = ST_OPENED;
                            end
                        end
                        PH_DOWN: begin
                            if (!r_entered) begin
                                o_cmd.dwell_clr = 1'b1;
                                n_entered       = 1'b1;
                            end else begin
                                o_cmd.dwell_inc = tick;
                                if (i_sts.down_done) begin
                                    n_phase   = PH_SELECT;
                                    n_entered = 1'b0;
                                end else begin
                                    n_entered = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // one candidate combination per cycle
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.exhausted) begin
                    o_cmd.load_last = 1'b1;
                    n_done          = ST_ALL;
                    n_entered       = 1'b1;
                    n_state         = S_RESULT;
                end else if (i_sts.valid) begin
                    n_phase   = i_sts.cw2 ? PH_CW2 : PH_THIRD;
                    n_entered = 1'b0;
                    n_state   = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SELECT;
            r_entered   <= 1'b0;
            r_done      <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_entered   <= n_entered;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_action <= n_action;
        r_sw     <= n_sw;
    end

endmodule

`default_nettype wire

// ===== rtl/core/lcss_dp.sv =====
// Sequencer datapath: configuration registers, digit scan, counters, output register.
// Depends on lcss_pkg; commanded by lcss_ctrl.
`default_nettype none

module lcss_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire lcss_pkg::t_dp_cmd  i_cmd,
    output lcss_pkg::t_dp_sts       o_sts,
    output logic [2:0]              o_motion_cmd,
    output logic [7:0]              o_target_position,
    output logic [7:0]              o_first_digit,
    output logic [7:0]              o_second_digit,
    output logic [7:0]              o_third_digit,
    output logic [15:0]             o_attempts,
    output logic [1:0]              o_status
);
    import lcss_pkg::*;

    // Configuration
    logic [POS_W-1:0]   r_first_zone, r_zone_step, r_pos_count, r_zone_count;
    logic [DWELL_W-1:0] r_up_wait, r_down_wait;

    // Sequencer state
    logic               r_assigned;
    logic [POS_W-1:0]   r_d1, r_d2, r_d3;
    logic [ATT_W-1:0]   r_attempts;
    logic [DWELL_W-1:0] r_dwell;

    // Scan working values
    logic [POS_W-1:0]   step, b1, b2, b3, n1, n2, n3;
    logic [POS_W:0]     t_sum, s_sum, f_sum, pc_ext, skip_pos;
    logic               exhausted;
    logic [POS_W-1:0]   last1, last2;
    logic [2*POS_W-1:0] prod1, prod2;
    logic [DWELL_W-1:0] dwell_next;
    logic [POS_W-1:0]   target;

    // A zero step behaves as one; the dial count never exceeds the digit range
    assign step   = (r_zone_step == '0) ? POS_W'(1) : r_zone_step;
    assign pc_ext = {1'b0, r_pos_count};

    // Digits start at the first zone before the first scan
    assign b1 = r_assigned ? r_d1 : r_first_zone;
    assign b2 = r_assigned ? r_d2 : r_first_zone;
    assign b3 = r_assigned ? r_d3 : r_first_zone;

    assign t_sum = {1'b0, b3} + {1'b0, step};
    assign s_sum = {1'b0, b2} + {1'b0, step};
    assign f_sum = {1'b0, b1} + {1'b0, step};

    // Odometer advance: third digit fastest, first slowest
    always_comb begin
        n1        = b1;
        n2        = b2;
        n3        = b3;
        exhausted = 1'b0;
        if (t_sum < pc_ext) begin
            n3 = t_sum[POS_W-1:0];
        end else begin
            n3 = r_first_zone;
            if (s_sum < pc_ext) begin
                n2 = s_sum[POS_W-1:0];
            end else begin
                n2 = r_first_zone;
                if (f_sum < pc_ext) begin
                    n1 = f_sum[POS_W-1:0];
                end else begin
                    exhausted = 1'b1;
                end
            end
        end
    end

    // Last valid combination: zone_count-1 and zone_count-2 zones up, wrapped
    assign prod1 = (r_zone_count - POS_W'(1)) * step;
    assign prod2 = (r_zone_count - POS_W'(2)) * step;
    assign last1 = r_first_zone + prod1[POS_W-1:0];
    assign last2 = r_first_zone + prod2[POS_W-1:0];

    // Position just past the first zone, unwrapped
    assign skip_pos = {1'b0, r_first_zone} + {1'b0, step};

    // Dwell after this step's tick, saturating
    assign dwell_next = (i_cmd.dwell_inc && r_dwell != '1) ? r_dwell + DWELL_W'(1) : r_dwell;

    // Status back to the controller
    always_comb begin
        o_sts.valid     = (n1 != n2) && (n2 != n3);
        o_sts.exhausted = exhausted;
        o_sts.cw2       = (n3 == r_first_zone) ||
                          ((n2 == r_first_zone) && ({1'b0, n3} == skip_pos));
        o_sts.up_done   = (dwell_next >= r_up_wait);
        o_sts.down_done = (dwell_next >= r_down_wait);
    end

    // Target digit for go-to motions
    always_comb begin
        case (i_cmd.out_motion)
            PH_FIRST:  target = r_d1;
            PH_SECOND: target = r_d2;
            PH_THIRD:  target = r_d3;
            default:   target = '0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_zone <= POS_W'(0);
            r_zone_step  <= POS_W'(2);
            r_pos_count  <= POS_W'(40);
            r_zone_count <= POS_W'(20);
            r_up_wait    <= DWELL_W'(500);
            r_down_wait  <= DWELL_W'(500);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_ZONE: r_first_zone <= i_cfg_data[POS_W-1:0];
                CFG_ZONE_STEP:  r_zone_step  <= i_cfg_data[POS_W-1:0];
                CFG_POS_COUNT:  r_pos_count  <= i_cfg_data[POS_W-1:0];
                CFG_ZONE_COUNT: r_zone_count <= i_cfg_data[POS_W-1:0];
                CFG_UP_WAIT:    r_up_wait    <= i_cfg_data[DWELL_W-1:0];
                CFG_DOWN_WAIT:  r_down_wait  <= i_cfg_data[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Digits, attempts and dwell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= 1'b0;
            r_d1       <= '0;
            r_d2       <= '0;
            r_d3       <= '0;
            r_attempts <= '0;
            r_dwell    <= '0;
        end else begin
            if (i_cmd.load_last) begin
                r_assigned <= 1'b1;
                r_d1       <= last1;
                r_d2       <= last2;
                r_d3       <= last1;
            end else if (i_cmd.scan) begin
                r_assigned <= 1'b1;
                r_d1       <= n1;
                r_d2       <= n2;
                r_d3       <= n3;
            end
            if (i_cmd.att_inc && r_attempts != '1) begin
                r_attempts <= r_attempts + ATT_W'(1);
            end
            if (i_cmd.dwell_clr) begin
                r_dwell <= '0;
            end else begin
                r_dwell <= dwell_next;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_motion_cmd      <= i_cmd.out_motion;
            o_target_position <= target;
            o_first_digit     <= r_d1;
            o_second_digit    <= r_d2;
            o_third_digit     <= r_d3;
            o_attempts        <= r_attempts;
            o_status          <= i_cmd.out_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lock_combination_sweep_sequencer_core.sv =====
// Top level of the lock combination sweep sequencer.
// Depends on lcss_pkg, lcss_ctrl and lcss_dp.
//
//  Channel  Direction  Handshake                 Payload
//  in       to block   i_in_valid / o_in_stall   i_action, i_switch_active
//  out      from block o_out_valid / i_out_stall o_motion_cmd .. o_status
//  cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item passes through accept, execute and load result when no new combination
// is chosen; choosing one adds a scan step for each candidate examined, since the
// skip loop steps one candidate per cycle through the digit adders.
// The result waits in the output register while i_out_stall is high; the next
// item is taken meanwhile and held in load result until the register frees.
// Reset is synchronous and loads the default values; the output register has none.
`default_nettype none

module lock_combination_sweep_sequencer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic        i_switch_active,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_motion_cmd,
    output logic [7:0]       o_target_position,
    output logic [7:0]       o_first_digit,
    output logic [7:0]       o_second_digit,
    output logic [7:0]       o_third_digit,
    output logic [15:0]      o_attempts,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import lcss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;

    lcss_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_switch_active (i_switch_active),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    lcss_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_motion_cmd      (o_motion_cmd),
        .o_target_position (o_target_position),
        .o_first_digit     (o_first_digit),
        .o_second_digit    (o_second_digit),
        .o_third_digit     (o_third_digit),
        .o_attempts        (o_attempts),
        .o_status          (o_status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lcss_checker.sv =====
// Port-level checks for the lock combination sweep sequencer, bound to the top level.
// Depends on lcss_pkg and lock_combination_sweep_sequencer_core.
`default_nettype none

module lcss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_motion_cmd,
    input wire logic [7:0]  o_target_position,
    input wire logic [7:0]  o_first_digit,
    input wire logic [7:0]  o_second_digit,
    input wire logic [7:0]  o_third_digit,
    input wire logic [1:0]  o_status
);
    import lcss_pkg::*;

    // A stalled result holds its valid and its command
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_motion_cmd))
        else $error("stalled result changed");

    // One item at a time: after a transfer in, the input stalls
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // A finished run commands no motion
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_RUN |-> o_motion_cmd == PH_SELECT)
        else $error("motion issued after completion");

    // Go-to motions carry the matching digit
    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_motion_cmd != PH_FIRST  || o_target_position == o_first_digit) &&
            (o_motion_cmd != PH_SECOND || o_target_position == o_second_digit) &&
            (o_motion_cmd != PH_THIRD  || o_target_position == o_third_digit))
        else $error("target does not match digit");

    // Other commands carry no target
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion_cmd != PH_FIRST && o_motion_cmd != PH_SECOND &&
        o_motion_cmd != PH_THIRD |-> o_target_position == '0)
        else $error("target set without go-to motion");

endmodule

bind lock_combination_sweep_sequencer_core lcss_checker u_lcss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_motion_cmd      (o_motion_cmd),
    .o_target_position (o_target_position),
    .o_first_digit     (o_first_digit),
    .o_second_digit    (o_second_digit),
    .o_third_digit     (o_third_digit),
    .o_status          (o_status)
);

`default_nettype wire
